// ===== rtl/blrq_pkg.sv =====
`timescale 1ns / 1ps
// blrq_pkg: shared types and constants for the button lockout repeat qualifier
// no dependencies; imported by every module of the block

package blrq_pkg;

    // configuration register file contents
    typedef struct packed {
        logic [7:0] button_lockout;
        logic [7:0] dpad_lockout;
        logic [7:0] save_hold;
        logic [7:0] back_hold;
        logic [3:0] fast_after;
        logic [7:0] fast_step;
    } cfg_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_BUTTON_LOCKOUT = 3'd0;
    localparam logic [2:0] REG_DPAD_LOCKOUT   = 3'd1;
    localparam logic [2:0] REG_SAVE_HOLD      = 3'd2;
    localparam logic [2:0] REG_BACK_HOLD      = 3'd3;
    localparam logic [2:0] REG_FAST_AFTER     = 3'd4;
    localparam logic [2:0] REG_FAST_STEP      = 3'd5;

    // register reset values
    localparam logic [7:0] RST_BUTTON_LOCKOUT = 8'd10;
    localparam logic [7:0] RST_DPAD_LOCKOUT   = 8'd15;
    localparam logic [7:0] RST_SAVE_HOLD      = 8'd5;
    localparam logic [7:0] RST_BACK_HOLD      = 8'd30;
    localparam logic [3:0] RST_FAST_AFTER     = 4'd10;
    localparam logic [7:0] RST_FAST_STEP      = 8'd10;

    localparam int unsigned BTN_W  = 12;
    localparam int unsigned MASK_W = 12;
    localparam int unsigned STEP_W = 8;

    // bit positions in the input button word
    localparam logic [3:0] BTN_A     = 4'd0;
    localparam logic [3:0] BTN_B     = 4'd1;
    localparam logic [3:0] BTN_X     = 4'd2;
    localparam logic [3:0] BTN_Y     = 4'd3;
    localparam logic [3:0] BTN_Z     = 4'd4;
    localparam logic [3:0] BTN_START = 4'd5;
    localparam logic [3:0] BTN_L     = 4'd6;
    localparam logic [3:0] BTN_R     = 4'd7;
    localparam logic [3:0] PAD_LEFT  = 4'd8;
    localparam logic [3:0] PAD_RIGHT = 4'd9;
    localparam logic [3:0] PAD_UP    = 4'd10;
    localparam logic [3:0] PAD_DOWN  = 4'd11;

    // bit positions in the press event mask
    localparam logic [3:0] EV_A        = 4'd0;
    localparam logic [3:0] EV_SAVE     = 4'd1;
    localparam logic [3:0] EV_BACK     = 4'd2;
    localparam logic [3:0] EV_UP       = 4'd3;
    localparam logic [3:0] EV_DOWN     = 4'd4;
    localparam logic [3:0] EV_LEFT     = 4'd5;
    localparam logic [3:0] EV_RIGHT    = 4'd6;
    localparam logic [3:0] EV_SHOULDER = 4'd7;
    localparam logic [3:0] EV_X        = 4'd8;
    localparam logic [3:0] EV_Y        = 4'd9;
    localparam logic [3:0] EV_Z        = 4'd10;
    localparam logic [3:0] EV_START    = 4'd11;

    // direction lockout slots
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [3:0] REPEAT_MAX = 4'd15;

    // count down toward zero, holding at zero
    function automatic logic [7:0] dec8(input logic [7:0] v);
        dec8 = (v != 8'd0) ? v - 8'd1 : v;
    endfunction

    // repeat count increment, stops past fast_after or at the top
    function automatic logic [3:0] bump_repeats(input logic [3:0] r, input logic [3:0] lim);
        bump_repeats = (r <= lim && r < REPEAT_MAX) ? r + 4'd1 : r;
    endfunction

endpackage

// ===== rtl/button_lockout_repeat_qualifier.sv =====
`timescale 1ns / 1ps
// button_lockout_repeat_qualifier: top level, stream ports, pipeline registers
// depends on blrq_pkg, blrq_cfg_regs, blrq_core

// One input word is one sampling tick of twelve button levels; each tick gives
// exactly one output word with a press event mask and a step size. The block
// takes one word per clock when the output side keeps up: a word is held in an
// input register, passes through the lockout and repeat logic in blrq_core, and
// lands in a result register, from where the result word is offered on
// m_tvalid. The lockout, hold and repeat state is updated in the same clock the
// result is registered, which is what lets the next tick follow directly. When
// the output is stalled both registers fill and s_tready drops; no word is lost.
// Settings are written through the apb port and must only change while no tick
// is in flight. Face buttons lock after firing until released for
// button_lockout ticks, d-pad directions repeat every dpad_lockout ticks, and
// holding B raises save and back events while masking every other button.

module button_lockout_repeat_qualifier (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] btn_a, [1] btn_b, [2] btn_x, [3] btn_y, [4] btn_z, [5] btn_start,
    // [6] btn_l, [7] btn_r, [8] pad_left, [9] pad_right, [10] pad_up,
    // [11] pad_down, [15:12] zero
    input  logic [15:0] s_tdata,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] press_mask, [19:12] step_size, [23:20] zero
    output logic [23:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import blrq_pkg::*;

    cfg_t               cfg;

    // input register
    logic               in_valid_reg;
    logic [BTN_W-1:0]   in_word_reg;
    // result register
    logic               out_valid_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic [STEP_W-1:0]  out_step_reg;

    logic               out_free;
    logic               advance;
    logic               s_take;
    logic [MASK_W-1:0]  core_mask;
    logic [STEP_W-1:0]  core_step;

    // result register can take a new word when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    blrq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blrq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_en    (advance),
        .btn        (in_word_reg),
        .press_mask (core_mask),
        .step_size  (core_step)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_take)
            in_word_reg <= s_tdata[BTN_W-1:0];
        if (advance)
        begin
            out_mask_reg <= core_mask;
            out_step_reg <= core_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_step_reg, out_mask_reg};

    // a word waiting in the input register stays until it moves on
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input word dropped while stalled");

    // at most one of the prioritized button events per tick
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones({out_mask_reg[EV_A], out_mask_reg[EV_Z],
            out_mask_reg[EV_START], out_mask_reg[EV_SHOULDER], out_mask_reg[EV_LEFT],
            out_mask_reg[EV_RIGHT], out_mask_reg[EV_UP], out_mask_reg[EV_DOWN]}) <= 1)
        else $error("more than one prioritized event in one tick");

    // save and back come only with B held, which masks all else
    a_b_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_mask_reg[EV_SAVE] || out_mask_reg[EV_BACK]) |->
            (out_mask_reg & ~((MASK_W'(1) << EV_SAVE) | (MASK_W'(1) << EV_BACK)))
                == '0)
        else $error("hold event mixed with other events");

    // a step other than one only comes with an up or down press
    a_fast_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_step_reg != 8'd1 |->
            out_mask_reg[EV_UP] || out_mask_reg[EV_DOWN])
        else $error("fast step without a vertical press");

endmodule

// ===== rtl/blrq_cfg_regs.sv =====
`timescale 1ns / 1ps
// blrq_cfg_regs: apb register file for the qualifier settings
// depends on blrq_pkg

module blrq_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output blrq_pkg::cfg_t      cfg
);
    import blrq_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_BUTTON_LOCKOUT: cfg_next.button_lockout = pwdata[7:0];
                REG_DPAD_LOCKOUT:   cfg_next.dpad_lockout   = pwdata[7:0];
                REG_SAVE_HOLD:      cfg_next.save_hold      = pwdata[7:0];
                REG_BACK_HOLD:      cfg_next.back_hold      = pwdata[7:0];
                REG_FAST_AFTER:     cfg_next.fast_after     = pwdata[3:0];
                REG_FAST_STEP:      cfg_next.fast_step      = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_lockout <= RST_BUTTON_LOCKOUT;
            cfg_reg.dpad_lockout   <= RST_DPAD_LOCKOUT;
            cfg_reg.save_hold      <= RST_SAVE_HOLD;
            cfg_reg.back_hold      <= RST_BACK_HOLD;
            cfg_reg.fast_after     <= RST_FAST_AFTER;
            cfg_reg.fast_step      <= RST_FAST_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BUTTON_LOCKOUT: prdata = {24'd0, cfg_reg.button_lockout};
            REG_DPAD_LOCKOUT:   prdata = {24'd0, cfg_reg.dpad_lockout};
            REG_SAVE_HOLD:      prdata = {24'd0, cfg_reg.save_hold};
            REG_BACK_HOLD:      prdata = {24'd0, cfg_reg.back_hold};
            REG_FAST_AFTER:     prdata = {28'd0, cfg_reg.fast_after};
            REG_FAST_STEP:      prdata = {24'd0, cfg_reg.fast_step};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/blrq_core.sv =====
`timescale 1ns / 1ps
// blrq_core: lockout, repeat and hold-count state with the per-tick event logic
// depends on blrq_pkg

module blrq_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  blrq_pkg::cfg_t                cfg,
    input  logic                          step_en,
    input  logic [blrq_pkg::BTN_W-1:0]    btn,
    output logic [blrq_pkg::MASK_W-1:0]   press_mask,
    output logic [blrq_pkg::STEP_W-1:0]   step_size
);
    import blrq_pkg::*;

    logic [7:0] a_lock_reg, a_lock_next;
    logic [7:0] z_lock_reg, z_lock_next;
    logic [7:0] start_lock_reg, start_lock_next;
    logic [7:0] shoulder_lock_reg, shoulder_lock_next;
    logic [7:0] dir_lock_reg [4];
    logic [7:0] dir_lock_next [4];
    logic [7:0] hold_count_reg, hold_count_next;
    logic [3:0] up_repeats_reg, up_repeats_next;
    logic [3:0] down_repeats_reg, down_repeats_next;

    logic       sh;
    logic       go_left;
    logic       go_right;
    logic [7:0] hold_inc;
    logic [3:0] up_bump;
    logic [3:0] down_bump;

    assign sh        = btn[BTN_L] | btn[BTN_R];
    assign hold_inc  = (hold_count_reg != 8'hff) ? hold_count_reg + 8'd1 : hold_count_reg;
    assign up_bump   = bump_repeats(up_repeats_reg, cfg.fast_after);
    assign down_bump = bump_repeats(down_repeats_reg, cfg.fast_after);

    always_comb
    begin
        // countdowns first, all later checks see the counted-down values
        a_lock_next        = btn[BTN_A]     ? a_lock_reg        : dec8(a_lock_reg);
        z_lock_next        = btn[BTN_Z]     ? z_lock_reg        : dec8(z_lock_reg);
        start_lock_next    = btn[BTN_START] ? start_lock_reg    : dec8(start_lock_reg);
        shoulder_lock_next = sh             ? shoulder_lock_reg : dec8(shoulder_lock_reg);
        for (int i = 0; i < 4; i++)
        begin
            dir_lock_next[i] = dec8(dir_lock_reg[i]);
        end
        hold_count_next   = hold_count_reg;
        up_repeats_next   = up_repeats_reg;
        down_repeats_next = down_repeats_reg;
        press_mask        = '0;
        step_size         = 8'd1;
        go_left  = btn[PAD_LEFT]  && (dir_lock_next[DIR_LEFT] == 8'd0);
        go_right = btn[PAD_RIGHT] && (dir_lock_next[DIR_RIGHT] == 8'd0);

        if (btn[BTN_B])
        begin
            hold_count_next = hold_inc;
            if (hold_inc == cfg.save_hold)
                press_mask[EV_SAVE] = 1'b1;
            if (hold_inc >= cfg.back_hold)
            begin
                hold_count_next     = 8'd0;
                a_lock_next         = 8'd0;
                press_mask[EV_BACK] = 1'b1;
            end
        end
        else
        begin
            hold_count_next = dec8(hold_count_reg);
            if (btn[BTN_A] && a_lock_next == 8'd0)
            begin
                press_mask[EV_A] = 1'b1;
                a_lock_next      = cfg.button_lockout;
            end
            else if (btn[BTN_Z] && z_lock_next == 8'd0)
            begin
                press_mask[EV_Z] = 1'b1;
                z_lock_next      = cfg.button_lockout;
            end
            else if (btn[BTN_START] && start_lock_next == 8'd0)
            begin
                press_mask[EV_START] = 1'b1;
                start_lock_next      = cfg.button_lockout;
            end
            else if (sh && shoulder_lock_next == 8'd0)
            begin
                press_mask[EV_SHOULDER] = 1'b1;
                shoulder_lock_next      = cfg.button_lockout;
            end
            else if (go_left || go_right)
            begin
                // left wins a tie with right
                if (go_left)
                begin
                    press_mask[EV_LEFT]     = 1'b1;
                    dir_lock_next[DIR_LEFT]  = cfg.dpad_lockout;
                    dir_lock_next[DIR_RIGHT] = 8'd0;
                end
                else
                begin
                    press_mask[EV_RIGHT]     = 1'b1;
                    dir_lock_next[DIR_RIGHT] = cfg.dpad_lockout;
                    dir_lock_next[DIR_LEFT]  = 8'd0;
                end
                dir_lock_next[DIR_UP]   = cfg.dpad_lockout;
                dir_lock_next[DIR_DOWN] = cfg.dpad_lockout;
                up_repeats_next         = 4'd0;
                down_repeats_next       = 4'd0;
            end
            else if (btn[PAD_UP] && dir_lock_next[DIR_UP] == 8'd0)
            begin
                press_mask[EV_UP]        = 1'b1;
                dir_lock_next[DIR_UP]    = cfg.dpad_lockout;
                dir_lock_next[DIR_DOWN]  = 8'd0;
                dir_lock_next[DIR_LEFT]  = cfg.dpad_lockout;
                dir_lock_next[DIR_RIGHT] = cfg.dpad_lockout;
                up_repeats_next          = up_bump;
                down_repeats_next        = 4'd0;
                step_size = (up_bump > cfg.fast_after) ? cfg.fast_step : 8'd1;
            end
            else if (btn[PAD_DOWN] && dir_lock_next[DIR_DOWN] == 8'd0)
            begin
                press_mask[EV_DOWN]      = 1'b1;
                dir_lock_next[DIR_DOWN]  = cfg.dpad_lockout;
                dir_lock_next[DIR_UP]    = 8'd0;
                dir_lock_next[DIR_LEFT]  = cfg.dpad_lockout;
                dir_lock_next[DIR_RIGHT] = cfg.dpad_lockout;
                down_repeats_next        = down_bump;
                up_repeats_next          = 4'd0;
                step_size = (down_bump > cfg.fast_after) ? cfg.fast_step : 8'd1;
            end
            else
            begin
                if (dir_lock_next[DIR_UP] == 8'd0)
                    up_repeats_next = 4'd0;
                if (dir_lock_next[DIR_DOWN] == 8'd0)
                    down_repeats_next = 4'd0;
            end
            press_mask[EV_X] = btn[BTN_X];
            press_mask[EV_Y] = btn[BTN_Y];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_lock_reg        <= 8'd0;
            z_lock_reg        <= 8'd0;
            start_lock_reg    <= 8'd0;
            shoulder_lock_reg <= 8'd0;
            for (int i = 0; i < 4; i++)
            begin
                dir_lock_reg[i] <= 8'd0;
            end
            hold_count_reg    <= 8'd0;
            up_repeats_reg    <= 4'd0;
            down_repeats_reg  <= 4'd0;
        end
        else if (step_en)
        begin
            a_lock_reg        <= a_lock_next;
            z_lock_reg        <= z_lock_next;
            start_lock_reg    <= start_lock_next;
            shoulder_lock_reg <= shoulder_lock_next;
            for (int i = 0; i < 4; i++)
            begin
                dir_lock_reg[i] <= dir_lock_next[i];
            end
            hold_count_reg    <= hold_count_next;
            up_repeats_reg    <= up_repeats_next;
            down_repeats_reg  <= down_repeats_next;
        end
    end

endmodule

// ===== test/blrq_checker.sv =====
`timescale 1ns / 1ps
// blrq_checker: watches the tick and result streams and the apb writes of the qualifier
// keeps its own copy of lockouts, hold count and repeat counts; depends on blrq_pkg

module blrq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int unsigned fail_count,
    output int unsigned backlog,
    output int unsigned words_checked
);
    import blrq_pkg::*;

    // same layout as m_tdata[19:0]
    typedef struct packed {
        logic [7:0]  step;
        logic [11:0] mask;
    } press_result_t;

    cfg_t          cfg;
    logic [7:0]    a_lock;
    logic [7:0]    z_lock;
    logic [7:0]    start_lock;
    logic [7:0]    shoulder_lock;
    logic [7:0]    hold_count;
    logic [7:0]    dir_lock [4];
    logic [3:0]    up_rep;
    logic [3:0]    down_rep;
    press_result_t pending_presses [$];
    int unsigned   fails;
    int unsigned   checked;

    function automatic logic [7:0] less_one(input logic [7:0] v);
        return (v == 8'd0) ? v : v - 8'd1;
    endfunction

    // one sampling tick: update the lockout state and return the events it raises
    function automatic press_result_t qualify_tick(input logic [11:0] lv);
        press_result_t r;
        logic          a, b, x, y, z, st, sh, pl, pr, pu, pd, go_left;
        a  = lv[BTN_A];
        b  = lv[BTN_B];
        x  = lv[BTN_X];
        y  = lv[BTN_Y];
        z  = lv[BTN_Z];
        st = lv[BTN_START];
        sh = lv[BTN_L] | lv[BTN_R];
        pl = lv[PAD_LEFT];
        pr = lv[PAD_RIGHT];
        pu = lv[PAD_UP];
        pd = lv[PAD_DOWN];
        r.mask = '0;
        r.step = 8'd1;

        // face buttons only count down while released, directions always
        if (!a)  a_lock        = less_one(a_lock);
        if (!sh) shoulder_lock = less_one(shoulder_lock);
        if (!z)  z_lock        = less_one(z_lock);
        if (!st) start_lock    = less_one(start_lock);
        foreach (dir_lock[i]) dir_lock[i] = less_one(dir_lock[i]);

        if (b) begin
            if (hold_count != 8'hFF) hold_count = hold_count + 8'd1;
            if (hold_count == cfg.save_hold) r.mask[EV_SAVE] = 1'b1;
            if (hold_count >= cfg.back_hold) begin
                hold_count       = 8'd0;
                a_lock           = 8'd0;
                r.mask[EV_BACK]  = 1'b1;
            end
        end else begin
            hold_count = less_one(hold_count);
            if (a && a_lock == 8'd0) begin
                r.mask[EV_A] = 1'b1;
                a_lock       = cfg.button_lockout;
            end else if (z && z_lock == 8'd0) begin
                r.mask[EV_Z] = 1'b1;
                z_lock       = cfg.button_lockout;
            end else if (st && start_lock == 8'd0) begin
                r.mask[EV_START] = 1'b1;
                start_lock       = cfg.button_lockout;
            end else if (sh && shoulder_lock == 8'd0) begin
                r.mask[EV_SHOULDER] = 1'b1;
                shoulder_lock       = cfg.button_lockout;
            end else if ((pl && dir_lock[DIR_LEFT] == 8'd0) ||
                         (pr && dir_lock[DIR_RIGHT] == 8'd0)) begin
                go_left = pl && dir_lock[DIR_LEFT] == 8'd0;
                if (go_left) begin
                    r.mask[EV_LEFT]     = 1'b1;
                    dir_lock[DIR_LEFT]  = cfg.dpad_lockout;
                    dir_lock[DIR_RIGHT] = 8'd0;
                end else begin
                    r.mask[EV_RIGHT]    = 1'b1;
                    dir_lock[DIR_RIGHT] = cfg.dpad_lockout;
                    dir_lock[DIR_LEFT]  = 8'd0;
                end
                dir_lock[DIR_UP]   = cfg.dpad_lockout;
                dir_lock[DIR_DOWN] = cfg.dpad_lockout;
                up_rep             = 4'd0;
                down_rep           = 4'd0;
            end else if (pu && dir_lock[DIR_UP] == 8'd0) begin
                r.mask[EV_UP]       = 1'b1;
                dir_lock[DIR_UP]    = cfg.dpad_lockout;
                dir_lock[DIR_DOWN]  = 8'd0;
                dir_lock[DIR_LEFT]  = cfg.dpad_lockout;
                dir_lock[DIR_RIGHT] = cfg.dpad_lockout;
                if (up_rep <= cfg.fast_after && up_rep < REPEAT_MAX) up_rep = up_rep + 4'd1;
                down_rep = 4'd0;
                if (up_rep > cfg.fast_after) r.step = cfg.fast_step;
            end else if (pd && dir_lock[DIR_DOWN] == 8'd0) begin
                r.mask[EV_DOWN]     = 1'b1;
                dir_lock[DIR_DOWN]  = cfg.dpad_lockout;
                dir_lock[DIR_UP]    = 8'd0;
                dir_lock[DIR_LEFT]  = cfg.dpad_lockout;
                dir_lock[DIR_RIGHT] = cfg.dpad_lockout;
                if (down_rep <= cfg.fast_after && down_rep < REPEAT_MAX)
                    down_rep = down_rep + 4'd1;
                up_rep = 4'd0;
                if (down_rep > cfg.fast_after) r.step = cfg.fast_step;
            end else begin
                // nothing fired: a run of repeats ends once its lockout ran out
                if (dir_lock[DIR_UP] == 8'd0)   up_rep   = 4'd0;
                if (dir_lock[DIR_DOWN] == 8'd0) down_rep = 4'd0;
            end
            r.mask[EV_X] = x;
            r.mask[EV_Y] = y;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        press_result_t got;
        press_result_t want;
        if (!rst_n) begin
            cfg.button_lockout = RST_BUTTON_LOCKOUT;
            cfg.dpad_lockout   = RST_DPAD_LOCKOUT;
            cfg.save_hold      = RST_SAVE_HOLD;
            cfg.back_hold      = RST_BACK_HOLD;
            cfg.fast_after     = RST_FAST_AFTER;
            cfg.fast_step      = RST_FAST_STEP;
            a_lock        = 8'd0;
            z_lock        = 8'd0;
            start_lock    = 8'd0;
            shoulder_lock = 8'd0;
            hold_count    = 8'd0;
            foreach (dir_lock[i]) dir_lock[i] = 8'd0;
            up_rep   = 4'd0;
            down_rep = 4'd0;
            pending_presses.delete();
            fails   = 0;
            checked = 0;
        end else begin
            // result words are always older than a tick taken at the same edge
            if (m_tvalid && m_tready) begin
                got = m_tdata[19:0];
                if (pending_presses.size() == 0) begin
                    $error("result word with nothing pending: press_mask %h step_size %0d",
                           got.mask, got.step);
                    fails++;
                end else begin
                    want = pending_presses.pop_front();
                    checked++;
                    if (got.mask !== want.mask) begin
                        $error("press_mask: expected %h, actual %h", want.mask, got.mask);
                        fails++;
                    end
                    if (got.step !== want.step) begin
                        $error("step_size: expected %0d, actual %0d", want.step, got.step);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) pending_presses.push_back(qualify_tick(s_tdata[11:0]));
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_BUTTON_LOCKOUT: cfg.button_lockout = pwdata[7:0];
                    REG_DPAD_LOCKOUT:   cfg.dpad_lockout   = pwdata[7:0];
                    REG_SAVE_HOLD:      cfg.save_hold      = pwdata[7:0];
                    REG_BACK_HOLD:      cfg.back_hold      = pwdata[7:0];
                    REG_FAST_AFTER:     cfg.fast_after     = pwdata[3:0];
                    REG_FAST_STEP:      cfg.fast_step      = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= fails;
        backlog       <= pending_presses.size();
        words_checked <= checked;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for button_lockout_repeat_qualifier
// depends on blrq_pkg, the rtl of the block and blrq_checker

module tb_top;
    import blrq_pkg::*;

    // receiver hold-off used to fill the block and stall its input
    localparam int unsigned HOLD_OFF_CYCLES = 60;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [11:0] button levels as in the block's port, [15:12] zero
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [11:0] press_mask, [19:12] step_size, [23:20] zero
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned fail_count;
    int unsigned backlog;
    int unsigned words_checked;

    // stimulus side bookkeeping
    bit          no_idle      = 1'b0;  // both sides run without gaps
    bit          hold_off_req = 1'b0;  // asks the receiver for one long stall
    int unsigned ticks_sent   = 0;
    int unsigned settings     = 0;
    logic [7:0]  cur_dpad     = RST_DPAD_LOCKOUT;
    logic [7:0]  cur_back     = RST_BACK_HOLD;

    always #1 clk = ~clk;

    button_lockout_repeat_qualifier i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    blrq_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .backlog       (backlog),
        .words_checked (words_checked)
    );

    // gap length for either side: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [11:0] btn(input logic [3:0] pos);
        return 12'(1) << pos;
    endfunction

    // offer one tick after an optional gap, return once it is taken
    task automatic send_tick(input logic [11:0] lv, input int unsigned gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lv};
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic hold_ticks(input logic [11:0] lv, input int unsigned n);
        repeat (n) send_tick(lv, idle_len());
    endtask

    // stop offering and wait for every pending result, plus the pipeline depth
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write; bits above the register width carry junk that the block must drop
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val,
                             input int unsigned w);
        logic [31:0] keep;
        keep = (32'd1 << w) - 32'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (32'($urandom) & ~keep) | (val & keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] bl, input logic [7:0] dl,
                             input logic [7:0] sh, input logic [7:0] bh,
                             input logic [3:0] fa, input logic [7:0] fs);
        write_reg(REG_BUTTON_LOCKOUT, 32'(bl), 8);
        write_reg(REG_DPAD_LOCKOUT,   32'(dl), 8);
        write_reg(REG_SAVE_HOLD,      32'(sh), 8);
        write_reg(REG_BACK_HOLD,      32'(bh), 8);
        write_reg(REG_FAST_AFTER,     32'(fa), 4);
        write_reg(REG_FAST_STEP,      32'(fs), 8);
        cur_dpad = dl;
        cur_back = bh;
        settings++;
    endtask

    // short directed opening at reset settings: priority order, lockouts,
    // opposite and perpendicular directions, b masking, x and y
    task automatic opening_ticks();
        logic [11:0] seq [24];
        seq = '{
            12'h000,
            12'hFFF,
            btn(BTN_A),
            btn(BTN_A),
            btn(BTN_Z) | btn(BTN_START) | btn(BTN_L),
            btn(BTN_START) | btn(BTN_L),
            btn(BTN_R),
            btn(PAD_LEFT) | btn(PAD_RIGHT),
            btn(PAD_RIGHT),
            btn(PAD_UP),
            btn(PAD_DOWN),
            btn(BTN_X),
            btn(BTN_Y),
            btn(BTN_B) | btn(BTN_X) | btn(BTN_Y),
            btn(BTN_B) | btn(BTN_A),
            btn(BTN_B),
            btn(BTN_B),
            btn(BTN_B) | btn(PAD_UP),
            12'h000,
            btn(PAD_UP) | btn(PAD_DOWN),
            12'h000,
            btn(PAD_UP),
            btn(PAD_DOWN),
            btn(BTN_A) | btn(BTN_X) | btn(BTN_Y)
        };
        foreach (seq[i]) send_tick(seq[i], idle_len());
    endtask

    // random runs of ticks shaped like real use: held sets, long b holds,
    // held directions that reach the repeat threshold, releases and some noise
    task automatic random_ticks(input int unsigned n);
        int unsigned sent;
        int unsigned len;
        int unsigned kind;
        int unsigned k;
        int unsigned pos;
        logic [11:0] lv;
        logic        b_level;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            lv   = 12'($urandom);
            case (kind)
                0, 1, 2: begin
                    if ($urandom_range(0, 3) != 0) lv[BTN_B] = 1'b0;
                    len = $urandom_range(1, 12);
                end
                3, 4: begin
                    lv[BTN_B] = 1'b1;
                    len = int'(cur_back) + $urandom_range(0, 6);
                end
                5, 6: begin
                    lv = '0;
                    case ($urandom_range(0, 5))
                        0, 1:    lv[PAD_UP]    = 1'b1;
                        2, 3:    lv[PAD_DOWN]  = 1'b1;
                        4:       lv[PAD_LEFT]  = 1'b1;
                        default: lv[PAD_RIGHT] = 1'b1;
                    endcase
                    lv[BTN_X] = 1'($urandom_range(0, 1));
                    lv[BTN_Y] = 1'($urandom_range(0, 1));
                    // now and then long enough to pass the fast threshold
                    if ($urandom_range(0, 3) == 0) len = (int'(cur_dpad) + 1) * 12;
                    else len = $urandom_range(4, 40);
                    if (len > 200) len = 200;
                end
                7:       len = $urandom_range(1, 10);
                default: begin
                    lv = '0;
                    lv[BTN_X] = 1'($urandom_range(0, 1));
                    len = $urandom_range(1, 15);
                end
            endcase
            b_level = lv[BTN_B];
            for (k = 0; k < len && sent < n; k++) begin
                if (kind == 7) begin
                    lv = 12'($urandom);
                end else if (kind <= 4 && $urandom_range(0, 7) == 0) begin
                    pos = $urandom_range(0, 11);
                    lv[pos] = ~lv[pos];
                    lv[BTN_B] = b_level;
                end
                send_tick(lv, idle_len());
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = idle_len();
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        opening_ticks();
        random_ticks(150);
        drain_results();

        // low extremes, no gaps on either side: b fires save and back every tick
        no_idle = 1'b1;
        configure(8'd0, 8'd0, 8'd1, 8'd1, 4'd0, 8'd255);
        random_ticks(100);
        drain_results();
        no_idle = 1'b0;

        // high extremes: b held until the count meets save and back together
        configure(8'd255, 8'd255, 8'd255, 8'd255, 4'd14, 8'd1);
        hold_ticks(btn(BTN_B) | btn(BTN_A), 258);
        random_ticks(120);
        drain_results();

        // mid-range settings with the output held off while ticks keep coming
        configure(8'($urandom_range(0, 6)), 8'($urandom_range(1, 8)),
                  8'($urandom_range(1, 20)), 8'($urandom_range(20, 40)),
                  4'($urandom_range(0, 14)), 8'($urandom_range(1, 255)));
        random_ticks(100);
        hold_off_req = 1'b1;
        hold_ticks(btn(PAD_DOWN) | btn(BTN_Y), 12);
        random_ticks(60);
        // sender waits until every result word is back, then goes on
        drain_results();
        random_ticks(60);
        drain_results();

        // direction fires every tick: repeat counts run up to their top
        configure(8'd1, 8'd0, 8'd3, 8'd9, 4'd14, 8'($urandom_range(1, 255)));
        hold_ticks(btn(PAD_UP), 24);
        hold_ticks(btn(PAD_DOWN), 20);
        random_ticks(80);
        drain_results();

        repeat (6) @(posedge clk);
        $display("summary: %0d ticks over %0d register settings, %0d result words checked",
                 ticks_sent, settings + 1, words_checked);
        if (fail_count == 0 && backlog == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // far beyond the slowest legal run: every word waiting out the longest gaps
    initial begin : watchdog
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
